[rtl/cmr_pkg.sv]
// Shared types, constants and helpers for the CIGAR match refiner.
package cmr_pkg;

   localparam int SEQ_DEPTH_DEF   = 65536;
   localparam int MATCH_CHUNK_DEF = 32;
   localparam int QUEUE_DEPTH     = 4;

   localparam int KIND_W  = 2;
   localparam int ADDR_W  = 16;
   localparam int BASE_W  = 3;
   localparam int OP_W    = 4;
   localparam int LEN_W   = 16;
   localparam int POS_W   = 20;
   localparam int IDX_W   = POS_W + 1;
   localparam int PIECE_W = 6;

   localparam logic [KIND_W-1:0] KIND_LOAD_Q = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_T = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OP     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

   localparam logic [OP_W-1:0] OP_NONE = 4'd0;
   localparam logic [OP_W-1:0] OP_M    = 4'd0;
   localparam logic [OP_W-1:0] OP_I    = 4'd1;
   localparam logic [OP_W-1:0] OP_D    = 4'd2;
   localparam logic [OP_W-1:0] OP_N    = 4'd3;
   localparam logic [OP_W-1:0] OP_S    = 4'd4;
   localparam logic [OP_W-1:0] OP_H    = 4'd5;
   localparam logic [OP_W-1:0] OP_EQ   = 4'd7;
   localparam logic [OP_W-1:0] OP_X    = 4'd8;

   localparam logic [LEN_W-1:0] RUN_MAX = 16'hFFFF;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
      logic [BASE_W-1:0] base;
      logic [OP_W-1:0]   op_code;
      logic [LEN_W-1:0]  op_count;
      logic              last_piece;
   } req_type;

   typedef struct packed {
      logic              is_summary;
      logic [OP_W-1:0]   run_op;
      logic [LEN_W-1:0]  run_length;
      logic [POS_W-1:0]  query_length;
      logic [POS_W-1:0]  target_length;
      logic [POS_W-1:0]  num_eq;
      logic [POS_W-1:0]  num_x;
      logic [POS_W-1:0]  num_ins;
      logic [POS_W-1:0]  num_del;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_LOAD_Q = 3'd0,
      CMD_LOAD_T = 3'd1,
      CMD_MATCH  = 3'd2,
      CMD_PASS   = 3'd3,
      CMD_END    = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ADDR_W-1:0] address;
      logic [BASE_W-1:0] base;
      logic [OP_W-1:0]   op;
      logic [LEN_W-1:0]  count;
      logic              last_piece;
   } cmd_type;

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {{(POS_W + 1 - LEN_W){1'b0}}, b};
      return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
   endfunction

   function automatic rsp_type make_run(input logic [OP_W-1:0] op,
                                        input logic [LEN_W-1:0] len);
      rsp_type r;
      r            = '0;
      r.run_op     = op;
      r.run_length = len;
      return r;
   endfunction

endpackage

[rtl/cmr_front.sv]
// Front end: classifies request beats into engine commands and drops the ignored ones.
module cmr_front
   import cmr_pkg::*;
#(
   parameter int SEQ_DEPTH   = SEQ_DEPTH_DEF,
   parameter int MATCH_CHUNK = MATCH_CHUNK_DEF
) (
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push_valid,
   output cmd_type push_cmd
);

   localparam logic [IDX_W-1:0] DEPTH_L = IDX_W'(SEQ_DEPTH);
   localparam logic [LEN_W-1:0] CHUNK_L = LEN_W'(MATCH_CHUNK);

   logic addr_ok;
   logic keep;

   assign addr_ok = {{(IDX_W - ADDR_W){1'b0}}, req_data.address} < DEPTH_L;

   always_comb begin
      keep                = 1'b0;
      push_cmd.kind       = CMD_PASS;
      push_cmd.address    = req_data.address;
      push_cmd.base       = req_data.base;
      push_cmd.op         = req_data.op_code;
      push_cmd.count      = req_data.op_count;
      push_cmd.last_piece = req_data.last_piece;
      case (req_data.kind)
         KIND_LOAD_Q: begin
            keep          = addr_ok;
            push_cmd.kind = CMD_LOAD_Q;
         end
         KIND_LOAD_T: begin
            keep          = addr_ok;
            push_cmd.kind = CMD_LOAD_T;
         end
         KIND_OP: begin
            case (req_data.op_code)
               OP_M: begin
                  keep           = 1'b1;
                  push_cmd.kind  = CMD_MATCH;
                  push_cmd.count = (req_data.op_count > CHUNK_L) ? CHUNK_L
                                                                 : req_data.op_count;
               end
               OP_I, OP_D, OP_N, OP_S, OP_H, OP_EQ, OP_X: begin
                  keep          = 1'b1;
                  push_cmd.kind = CMD_PASS;
               end
               default: keep = 1'b0;
            endcase
         end
         KIND_END: begin
            keep          = 1'b1;
            push_cmd.kind = CMD_END;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_stall  = queue_full;
   assign push_valid = req_valid && keep;

endmodule

[rtl/cmr_queue.sv]
// Command queue between the front end and the engine.
module cmr_queue
   import cmr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/cmr_back.sv]
// Engine: base stores, match walk, run tracking, totals and the result register.
module cmr_back
   import cmr_pkg::*;
#(
   parameter int SEQ_DEPTH = SEQ_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   input  cmd_type pop_cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int               AW      = $clog2(SEQ_DEPTH);
   localparam logic [IDX_W-1:0] DEPTH_L = IDX_W'(SEQ_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WALK  = 5'b00010,
      S_FLUSH = 5'b00100,
      S_EMIT  = 5'b01000,
      S_DONE  = 5'b10000
   } back_state_type;

   logic [BASE_W-1:0] q_mem [SEQ_DEPTH];
   logic [BASE_W-1:0] t_mem [SEQ_DEPTH];

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [PIECE_W-1:0] m_ff, m_in;
   logic [POS_W-1:0]   qpos_ff, qpos_in;
   logic [POS_W-1:0]   tpos_ff, tpos_in;
   logic               open_mis_ff, open_mis_in;
   logic [LEN_W-1:0]   open_len_ff, open_len_in;
   logic [POS_W-1:0]   eq_tot_ff, eq_tot_in;
   logic [POS_W-1:0]   x_tot_ff, x_tot_in;
   logic [POS_W-1:0]   ins_tot_ff, ins_tot_in;
   logic [POS_W-1:0]   del_tot_ff, del_tot_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_type            pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [BASE_W-1:0]  q_rd_ff;
   logic [BASE_W-1:0]  t_rd_ff;
   logic               rd_ok_ff;

   logic               q_we;
   logic               t_we;
   logic [IDX_W-1:0]   w_full;
   logic [AW-1:0]      w_idx;
   logic               rd_en;
   logic [PIECE_W-1:0] rd_m;
   logic [IDX_W-1:0]   q_full_idx;
   logic [IDX_W-1:0]   t_full_idx;
   logic               q_ok;
   logic               t_ok;
   logic [AW-1:0]      q_ridx;
   logic [AW-1:0]      t_ridx;
   logic [PIECE_W-1:0] piece;
   logic               mis;
   logic               need_close;
   logic               out_free;
   logic               can_push;
   logic               push_en;
   rsp_type            push_data;
   rsp_type            close_run;
   rsp_type            summary;
   back_state_type     flush_next;

   assign w_full     = {{(IDX_W - ADDR_W){1'b0}}, pop_cmd.address};
   assign w_idx      = w_full[AW-1:0];
   assign q_full_idx = {1'b0, qpos_ff} + IDX_W'(rd_m);
   assign t_full_idx = {1'b0, tpos_ff} + IDX_W'(rd_m);
   assign q_ok       = q_full_idx < DEPTH_L;
   assign t_ok       = t_full_idx < DEPTH_L;
   assign q_ridx     = q_ok ? q_full_idx[AW-1:0] : '0;
   assign t_ridx     = t_ok ? t_full_idx[AW-1:0] : '0;

   assign piece      = cmd_ff.count[PIECE_W-1:0];
   assign mis        = !(rd_ok_ff && (q_rd_ff == t_rd_ff));
   assign need_close = (open_len_ff != '0) &&
                       ((open_mis_ff != mis) || (open_len_ff == RUN_MAX));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign can_push   = !pend_valid_ff || out_free;
   assign close_run  = make_run(open_mis_ff ? OP_X : OP_EQ, open_len_ff);
   assign flush_next = (cmd_ff.kind == CMD_MATCH) ? S_DONE : S_EMIT;

   always_comb begin
      summary               = '0;
      summary.is_summary    = 1'b1;
      summary.query_length  = qpos_ff;
      summary.target_length = tpos_ff;
      summary.num_eq        = eq_tot_ff;
      summary.num_x         = x_tot_ff;
      summary.num_ins       = ins_tot_ff;
      summary.num_del       = del_tot_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      m_in          = m_ff;
      qpos_in       = qpos_ff;
      tpos_in       = tpos_ff;
      open_mis_in   = open_mis_ff;
      open_len_in   = open_len_ff;
      eq_tot_in     = eq_tot_ff;
      x_tot_in      = x_tot_ff;
      ins_tot_in    = ins_tot_ff;
      del_tot_in    = del_tot_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      q_we          = 1'b0;
      t_we          = 1'b0;
      rd_en         = 1'b0;
      rd_m          = '0;
      push_en       = 1'b0;
      push_data     = close_run;

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               pop    = 1'b1;
               cmd_in = pop_cmd;
               case (pop_cmd.kind)
                  CMD_LOAD_Q: q_we = 1'b1;
                  CMD_LOAD_T: t_we = 1'b1;
                  CMD_MATCH: begin
                     if (pop_cmd.count == '0) begin
                        state_in = pop_cmd.last_piece ? S_FLUSH : S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        m_in     = '0;
                        state_in = S_WALK;
                     end
                  end
                  CMD_PASS, CMD_END: state_in = S_FLUSH;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_WALK: begin
            if (!need_close || can_push) begin
               if (need_close) begin
                  push_en = 1'b1;
                  if (open_mis_ff) begin
                     x_tot_in = sat_add(x_tot_ff, open_len_ff);
                  end else begin
                     eq_tot_in = sat_add(eq_tot_ff, open_len_ff);
                  end
                  open_mis_in = mis;
                  open_len_in = LEN_W'(1);
               end else if (open_len_ff == '0) begin
                  open_mis_in = mis;
                  open_len_in = LEN_W'(1);
               end else begin
                  open_len_in = LEN_W'(open_len_ff + 1'b1);
               end
               if (PIECE_W'(m_ff + 1'b1) == piece) begin
                  qpos_in  = sat_add(qpos_ff, cmd_ff.count);
                  tpos_in  = sat_add(tpos_ff, cmd_ff.count);
                  state_in = cmd_ff.last_piece ? S_FLUSH : S_DONE;
               end else begin
                  m_in  = PIECE_W'(m_ff + 1'b1);
                  rd_en = 1'b1;
                  rd_m  = PIECE_W'(m_ff + 1'b1);
               end
            end
         end
         S_FLUSH: begin
            if (open_len_ff == '0) begin
               state_in = flush_next;
            end else if (can_push) begin
               push_en = 1'b1;
               if (open_mis_ff) begin
                  x_tot_in = sat_add(x_tot_ff, open_len_ff);
               end else begin
                  eq_tot_in = sat_add(eq_tot_ff, open_len_ff);
               end
               open_len_in = '0;
               open_mis_in = 1'b0;
               state_in    = flush_next;
            end
         end
         S_EMIT: begin
            if (can_push) begin
               push_en  = 1'b1;
               state_in = S_DONE;
               if (cmd_ff.kind == CMD_END) begin
                  push_data   = summary;
                  qpos_in     = '0;
                  tpos_in     = '0;
                  open_mis_in = 1'b0;
                  open_len_in = '0;
                  eq_tot_in   = '0;
                  x_tot_in    = '0;
                  ins_tot_in  = '0;
                  del_tot_in  = '0;
               end else begin
                  push_data = make_run(cmd_ff.op, cmd_ff.count);
                  case (cmd_ff.op)
                     OP_I: begin
                        ins_tot_in = sat_add(ins_tot_ff, cmd_ff.count);
                        qpos_in    = sat_add(qpos_ff, cmd_ff.count);
                     end
                     OP_S: qpos_in = sat_add(qpos_ff, cmd_ff.count);
                     OP_D: begin
                        del_tot_in = sat_add(del_tot_ff, cmd_ff.count);
                        tpos_in    = sat_add(tpos_ff, cmd_ff.count);
                     end
                     OP_N: tpos_in = sat_add(tpos_ff, cmd_ff.count);
                     OP_EQ: begin
                        eq_tot_in = sat_add(eq_tot_ff, cmd_ff.count);
                        qpos_in   = sat_add(qpos_ff, cmd_ff.count);
                        tpos_in   = sat_add(tpos_ff, cmd_ff.count);
                     end
                     OP_X: begin
                        x_tot_in = sat_add(x_tot_ff, cmd_ff.count);
                        qpos_in  = sat_add(qpos_ff, cmd_ff.count);
                        tpos_in  = sat_add(tpos_ff, cmd_ff.count);
                     end
                     default: qpos_in = qpos_ff;
                  endcase
               end
            end
         end
         S_DONE: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // hold the newest result back until the next one or the end of the item
      if (push_en) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
         end
         pend_valid_in = 1'b1;
         pend_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         qpos_ff       <= '0;
         tpos_ff       <= '0;
         open_mis_ff   <= 1'b0;
         open_len_ff   <= '0;
         eq_tot_ff     <= '0;
         x_tot_ff      <= '0;
         ins_tot_ff    <= '0;
         del_tot_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         qpos_ff       <= qpos_in;
         tpos_ff       <= tpos_in;
         open_mis_ff   <= open_mis_in;
         open_len_ff   <= open_len_in;
         eq_tot_ff     <= eq_tot_in;
         x_tot_ff      <= x_tot_in;
         ins_tot_ff    <= ins_tot_in;
         del_tot_ff    <= del_tot_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      m_ff    <= m_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[w_idx] <= pop_cmd.base;
      end
      if (t_we) begin
         t_mem[w_idx] <= pop_cmd.base;
      end
      if (rd_en) begin
         q_rd_ff  <= q_mem[q_ridx];
         t_rd_ff  <= t_mem[t_ridx];
         rd_ok_ff <= q_ok && t_ok;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("held result left over between items");

   a_walk_in_piece: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (m_ff < piece))
      else $error("match walk ran past its piece");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_summary) |-> rsp_ff.last)
      else $error("summary beat not marked last");

   a_run_op: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.is_summary) |-> (rsp_ff.run_op != OP_M))
      else $error("run beat carries a bare match op");
`endif

endmodule

[rtl/cigar_match_refiner.sv]
// Usage:
// Request channel (req_valid / req_stall / req_data) takes one beat per item:
// base loads into the query or target store, CIGAR ops, or an end marker.
// Response channel (rsp_valid / rsp_stall / rsp_data) returns run beats and
// one summary beat per end marker; last marks the final beat of an item.
// A front end classifies beats into a four-deep command queue; beats that
// make no result (ignored ops, loads beyond the store) are dropped there.
// The engine serves one command at a time. An M piece walks both stores one
// base pair per cycle through registered reads, unless a finished run waits
// for the output. The newest result is held one step so the last flag can
// be set. Reset clears positions, the open run, totals and all valid flags;
// store contents stay undefined until written.
// While rsp_stall is high the output beat holds and the engine waits at its
// next result; the queue keeps taking request beats until it fills.
module cigar_match_refiner
   import cmr_pkg::*;
#(
   parameter int SEQ_DEPTH   = SEQ_DEPTH_DEF,
   parameter int MATCH_CHUNK = MATCH_CHUNK_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    queue_full;
   logic    push_valid;
   cmd_type push_cmd;
   logic    pop;
   logic    pop_valid;
   cmd_type pop_cmd;

   cmr_front #(
      .SEQ_DEPTH   (SEQ_DEPTH),
      .MATCH_CHUNK (MATCH_CHUNK)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   cmr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   cmr_back #(
      .SEQ_DEPTH (SEQ_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/tb.sv]
// Testbench for cigar_match_refiner: directed and random CIGAR streams checked beat by beat.
module tb;
   import cmr_pkg::*;

   localparam int STORE_DEPTH   = SEQ_DEPTH_DEF;
   localparam int CHUNK         = MATCH_CHUNK_DEF;
   localparam int PHASE_ITEMS   = 40;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int LONG_PIECES   = 6;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [OP_W-1:0] OP_P    = 4'd6;
   localparam logic [OP_W-1:0] OP_LAST = 4'd15;

   localparam logic [BASE_W-1:0] BASE_A   = 3'd0;
   localparam logic [BASE_W-1:0] BASE_C   = 3'd1;
   localparam logic [BASE_W-1:0] BASE_G   = 3'd2;
   localparam logic [BASE_W-1:0] BASE_AMB = 3'd4;
   localparam logic [BASE_W-1:0] BASE_TOP = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic [BASE_W-1:0] query_store  [0:STORE_DEPTH-1];
   logic [BASE_W-1:0] target_store [0:STORE_DEPTH-1];
   bit                query_loaded [0:STORE_DEPTH-1];
   bit                target_loaded[0:STORE_DEPTH-1];

   logic [POS_W-1:0] query_pos;
   logic [POS_W-1:0] target_pos;
   logic [POS_W-1:0] eq_count;
   logic [POS_W-1:0] x_count;
   logic [POS_W-1:0] ins_count;
   logic [POS_W-1:0] del_count;
   logic             run_is_x;
   logic [LEN_W-1:0] run_len;

   rsp_type item_beats[$];
   rsp_type pending_beats[$];
   rsp_type want_beat;

   int idle_pct;
   int stall_pct;
   int hold_left;
   int accepted_items;
   int error_count;

   cigar_match_refiner uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [POS_W-1:0] clamp_add(input logic [POS_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {{(POS_W + 1 - LEN_W){1'b0}}, b};
      return s[POS_W] ? POS_MAX : s[POS_W-1:0];
   endfunction

   function automatic bit is_pass_op(input logic [OP_W-1:0] op);
      return (op >= OP_I && op <= OP_H) || op == OP_EQ || op == OP_X;
   endfunction

   function automatic logic [OP_W-1:0] pass_op(input int k);
      case (k)
         0:       return OP_I;
         1:       return OP_D;
         2:       return OP_N;
         3:       return OP_S;
         4:       return OP_H;
         5:       return OP_EQ;
         default: return OP_X;
      endcase
   endfunction

   function automatic void clear_alignment();
      query_pos  = '0;
      target_pos = '0;
      eq_count   = '0;
      x_count    = '0;
      ins_count  = '0;
      del_count  = '0;
      run_is_x   = 1'b0;
      run_len    = '0;
   endfunction

   function automatic void push_run(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len);
      rsp_type r;
      r            = '0;
      r.run_op     = op;
      r.run_length = len;
      item_beats.push_back(r);
   endfunction

   function automatic void close_run();
      if (run_len == 0)
         return;
      if (run_is_x) begin
         push_run(OP_X, run_len);
         x_count = clamp_add(x_count, run_len);
      end else begin
         push_run(OP_EQ, run_len);
         eq_count = clamp_add(eq_count, run_len);
      end
      run_len  = '0;
      run_is_x = 1'b0;
   endfunction

   function automatic void expand_cigar_item(input req_type item);
      int unsigned piece;
      logic [IDX_W-1:0] qi;
      logic [IDX_W-1:0] ti;
      logic mis;
      rsp_type r;
      item_beats.delete();
      case (item.kind)
         KIND_LOAD_Q: begin
            query_store[item.address]  = item.base;
            query_loaded[item.address] = 1'b1;
         end
         KIND_LOAD_T: begin
            target_store[item.address]  = item.base;
            target_loaded[item.address] = 1'b1;
         end
         KIND_OP: begin
            if (item.op_code == OP_M) begin
               piece = item.op_count > CHUNK ? CHUNK : item.op_count;
               for (int m = 0; m < piece; m++) begin
                  qi  = {1'b0, query_pos} + IDX_W'(m);
                  ti  = {1'b0, target_pos} + IDX_W'(m);
                  mis = !(qi < STORE_DEPTH && ti < STORE_DEPTH &&
                          query_store[qi[ADDR_W-1:0]] == target_store[ti[ADDR_W-1:0]]);
                  if (run_len > 0 && (run_is_x != mis || run_len == RUN_MAX))
                     close_run();
                  if (run_len == 0) begin
                     run_is_x = mis;
                     run_len  = 1;
                  end else begin
                     run_len++;
                  end
               end
               query_pos  = clamp_add(query_pos, LEN_W'(piece));
               target_pos = clamp_add(target_pos, LEN_W'(piece));
               if (item.last_piece)
                  close_run();
            end else if (is_pass_op(item.op_code)) begin
               close_run();
               push_run(item.op_code, item.op_count);
               case (item.op_code)
                  OP_I: begin
                     ins_count = clamp_add(ins_count, item.op_count);
                     query_pos = clamp_add(query_pos, item.op_count);
                  end
                  OP_S: query_pos = clamp_add(query_pos, item.op_count);
                  OP_D: begin
                     del_count  = clamp_add(del_count, item.op_count);
                     target_pos = clamp_add(target_pos, item.op_count);
                  end
                  OP_N: target_pos = clamp_add(target_pos, item.op_count);
                  OP_EQ, OP_X: begin
                     if (item.op_code == OP_EQ)
                        eq_count = clamp_add(eq_count, item.op_count);
                     else
                        x_count = clamp_add(x_count, item.op_count);
                     query_pos  = clamp_add(query_pos, item.op_count);
                     target_pos = clamp_add(target_pos, item.op_count);
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            close_run();
            r               = '0;
            r.is_summary    = 1'b1;
            r.run_op        = OP_NONE;
            r.query_length  = query_pos;
            r.target_length = target_pos;
            r.num_eq        = eq_count;
            r.num_x         = x_count;
            r.num_ins       = ins_count;
            r.num_del       = del_count;
            item_beats.push_back(r);
            clear_alignment();
         end
      endcase
      if (item_beats.size() > 0)
         item_beats[item_beats.size()-1].last = 1'b1;
      foreach (item_beats[k])
         pending_beats.push_back(item_beats[k]);
   endfunction

   function automatic req_type filler(input logic [KIND_W-1:0] kind);
      logic [63:0] raw;
      req_type item;
      raw       = {$urandom(), $urandom()};
      item      = raw[$bits(req_type)-1:0];
      item.kind = kind;
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expand_cigar_item(item);
      if (item.kind != KIND_OP || item.op_code == OP_M || is_pass_op(item.op_code))
         accepted_items++;
      @(negedge clock);
   endtask

   task automatic send_load(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                            input logic [BASE_W-1:0] base);
      req_type item;
      item         = filler(kind);
      item.address = addr;
      item.base    = base;
      send_item(item);
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] count,
                          input logic ends);
      req_type item;
      item            = filler(KIND_OP);
      item.op_code    = op;
      item.op_count   = count;
      item.last_piece = ends;
      send_item(item);
   endtask

   task automatic send_end();
      send_item(filler(KIND_END));
   endtask

   task automatic load_window(input int piece);
      int qi;
      int ti;
      logic [BASE_W-1:0] b;
      for (int m = 0; m < piece; m++) begin
         qi = query_pos + m;
         ti = target_pos + m;
         if (qi < STORE_DEPTH && (!query_loaded[qi] || $urandom_range(9) == 0)) begin
            if (ti < STORE_DEPTH && target_loaded[ti] && $urandom_range(9) < 7)
               b = target_store[ti];
            else
               b = BASE_W'($urandom_range(7));
            send_load(KIND_LOAD_Q, ADDR_W'(qi), b);
         end
         if (ti < STORE_DEPTH && (!target_loaded[ti] || $urandom_range(9) == 0)) begin
            if (qi < STORE_DEPTH && query_loaded[qi] && $urandom_range(9) < 7)
               b = query_store[qi];
            else
               b = BASE_W'($urandom_range(7));
            send_load(KIND_LOAD_T, ADDR_W'(ti), b);
         end
      end
   endtask

   task automatic send_match(input logic [LEN_W-1:0] count, input logic ends);
      load_window(count > CHUNK ? CHUNK : count);
      send_op(OP_M, count, ends);
   endtask

   task automatic send_match_op(input int total);
      int left;
      int cnt;
      left = total;
      do begin
         cnt = left;
         if (left > CHUNK && $urandom_range(9) == 0)
            cnt = $urandom_range(65535, CHUNK + 1);
         send_match(LEN_W'(cnt), left <= CHUNK);
         left -= (left > CHUNK) ? CHUNK : left;
      end while (left > 0);
   endtask

   task automatic random_alignment();
      int n_ops;
      int pick;
      logic [OP_W-1:0] op;
      n_ops = $urandom_range(8, 1);
      repeat (n_ops) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_match_op($urandom_range(80));
         end else if (pick < 50) begin
            send_match(LEN_W'($urandom_range(CHUNK)), 1'b0);
         end else if (pick < 55) begin
            op = ($urandom_range(7) == 0) ? OP_P : OP_W'(OP_X + $urandom_range(7, 1));
            send_op(op, LEN_W'($urandom()), 1'($urandom()));
         end else begin
            op = pass_op($urandom_range(6));
            send_op(op, ($urandom_range(19) == 0) ? LEN_W'($urandom())
                                                  : LEN_W'($urandom_range(20)),
                    1'($urandom()));
         end
      end
      if ($urandom_range(9) != 0)
         send_end();
   endtask

   task automatic test_directed_cases();
      idle_pct  = 0;
      stall_pct = 0;
      send_load(KIND_LOAD_Q, 0, BASE_A);
      send_load(KIND_LOAD_T, 0, BASE_A);
      send_load(KIND_LOAD_Q, 1, BASE_AMB);
      send_load(KIND_LOAD_T, 1, BASE_AMB);
      send_load(KIND_LOAD_Q, 2, BASE_TOP);
      send_load(KIND_LOAD_T, 2, BASE_TOP);
      send_load(KIND_LOAD_Q, 3, BASE_C);
      send_load(KIND_LOAD_T, 3, BASE_G);
      send_load(KIND_LOAD_Q, 16'hFFFF, BASE_TOP);
      send_load(KIND_LOAD_T, 16'hFFFF, BASE_A);
      send_op(OP_M, 4, 1'b0);
      send_op(OP_I, 0, 1'b0);
      send_op(OP_H, 3, 1'b0);
      send_op(OP_P, 9, 1'b0);
      send_op(OP_LAST, 16'hFFFF, 1'b1);
      send_op(OP_N, 2, 1'b0);
      send_op(OP_S, 1, 1'b0);
      send_op(OP_EQ, 0, 1'b0);
      send_op(OP_M, 0, 1'b1);
      send_op(OP_X, 5, 1'b0);
      send_op(OP_D, 16'hFFFF, 1'b0);
      send_match(2, 1'b0);
      send_end();
   endtask

   task automatic test_random_alignments(input int idle, input int stall);
      int goal;
      idle_pct  = idle;
      stall_pct = stall;
      goal      = accepted_items + PHASE_ITEMS;
      while (accepted_items < goal)
         random_alignment();
   endtask

   task automatic test_saturation();
      idle_pct  = 24;
      stall_pct = 24;
      repeat (17) begin
         send_op(OP_I, LEN_W'($urandom_range(65535, 62000)), 1'b0);
         send_op(OP_D, LEN_W'($urandom_range(65535, 62000)), 1'b0);
         send_op(OP_EQ, LEN_W'($urandom_range(65535, 62000)), 1'b0);
         send_op(OP_X, LEN_W'($urandom_range(65535, 62000)), 1'b0);
      end
      send_match(CHUNK, 1'b1);
      send_end();
   endtask

   task automatic test_long_run();
      idle_pct  = 0;
      stall_pct = 0;
      send_op(OP_I, RUN_MAX, 1'b0);
      send_op(OP_S, RUN_MAX, 1'b0);
      send_op(OP_D, RUN_MAX, 1'b0);
      send_op(OP_N, RUN_MAX, 1'b0);
      for (int k = 0; k < LONG_PIECES; k++)
         send_match(RUN_MAX, k == LONG_PIECES - 1);
      send_end();
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      send_op(OP_I, RUN_MAX, 1'b0);
      send_op(OP_S, RUN_MAX, 1'b0);
      send_op(OP_D, RUN_MAX, 1'b0);
      send_op(OP_N, RUN_MAX, 1'b0);
      req_valid <= 1'b0;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      repeat (30) begin
         if ($urandom_range(1))
            send_match(LEN_W'($urandom_range(CHUNK, 1)), 1'b1);
         else
            send_op(pass_op($urandom_range(4)), LEN_W'($urandom_range(20)), 1'b0);
      end
      send_end();
   endtask

   task automatic check_field(input string name, input logic [POS_W-1:0] want,
                              input logic [POS_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            error_count++;
            $display("%0t unexpected beat: expected none actual %h", $time, rsp_data);
         end else begin
            want_beat = pending_beats.pop_front();
            check_field("is_summary", POS_W'(want_beat.is_summary),
                        POS_W'(rsp_data.is_summary));
            check_field("run_op", POS_W'(want_beat.run_op), POS_W'(rsp_data.run_op));
            check_field("run_length", POS_W'(want_beat.run_length),
                        POS_W'(rsp_data.run_length));
            check_field("query_length", want_beat.query_length, rsp_data.query_length);
            check_field("target_length", want_beat.target_length, rsp_data.target_length);
            check_field("num_eq", want_beat.num_eq, rsp_data.num_eq);
            check_field("num_x", want_beat.num_x, rsp_data.num_x);
            check_field("num_ins", want_beat.num_ins, rsp_data.num_ins);
            check_field("num_del", want_beat.num_del, rsp_data.num_del);
            check_field("last", POS_W'(want_beat.last), POS_W'(rsp_data.last));
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      hold_left      = 0;
      accepted_items = 0;
      error_count    = 0;
      clear_alignment();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_alignments(0, 0);
      test_random_alignments(83, 0);
      test_random_alignments(0, 83);
      test_random_alignments(24, 24);
      test_saturation();
      test_long_run();
      test_backpressure();

      req_valid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      while (pending_beats.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
